>>> hw/rtl/swrr_pkg.sv
// Shared constants and types for the smooth weighted round-robin picker.
package swrr_pkg;

  localparam int NUM_REGS    = 8;     // weight registers on the config port
  localparam int WEIGHT_W    = 8;
  localparam int IDX_W       = 3;     // server index / schedule entry width
  localparam int TOTAL_W     = 12;    // sum of up to eight 8-bit weights
  localparam int RUN_W       = 13;    // signed running weight
  localparam int PADDR_W     = 5;
  localparam int PDATA_W     = 32;
  localparam int REG_LSB     = 2;     // registers on 4-byte strides
  localparam int S_TDATA_W   = 8;
  localparam int M_TDATA_W   = 8;
  localparam int SERVERS_DEF = 8;
  localparam int DEPTH_DEF   = 2048;

  typedef logic [WEIGHT_W-1:0] weight_t;
  typedef logic [NUM_REGS-1:0][WEIGHT_W-1:0] weights_t;

endpackage

>>> hw/rtl/swrr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module swrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/swrr_build.sv
// Schedule builder: one server per cycle through a shared add/compare unit.
module swrr_build #(
  parameter int SERVERS        = swrr_pkg::SERVERS_DEF,
  parameter int SCHEDULE_DEPTH = swrr_pkg::DEPTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  swrr_pkg::weights_t                    weights_i,
  output logic                                  busy_o,
  output logic [$clog2(SCHEDULE_DEPTH+1)-1:0]   len_o,
  output logic                                  wr_en_o,
  output logic [$clog2(SCHEDULE_DEPTH)-1:0]     wr_addr_o,
  output logic [swrr_pkg::IDX_W-1:0]            wr_data_o
);
  import swrr_pkg::*;

  localparam int SRV_W  = (SERVERS > 1) ? $clog2(SERVERS) : 1;
  localparam int ADDR_W = $clog2(SCHEDULE_DEPTH);
  localparam int LEN_W  = $clog2(SCHEDULE_DEPTH + 1);
  localparam int CMP_W  = (LEN_W > TOTAL_W) ? LEN_W : TOTAL_W;
  localparam logic [SRV_W-1:0] LAST_SRV = SRV_W'(SERVERS - 1);

  typedef enum logic [1:0] {ST_IDLE, ST_SUM, ST_SLOT} state_e;

  state_e                   state_q, state_d;
  logic [SRV_W-1:0]         srv_q, srv_d;
  logic [ADDR_W-1:0]        slot_q, slot_d;
  logic [LEN_W-1:0]         len_q, len_d;
  logic [TOTAL_W-1:0]       total_q, total_d;
  logic signed [RUN_W-1:0]  ring_q [SERVERS];
  logic signed [RUN_W-1:0]  ring_d [SERVERS];
  logic signed [RUN_W-1:0]  top_q, top_d;
  logic [IDX_W-1:0]         best_q, best_d;
  logic                     found_q, found_d;
  logic [IDX_W-1:0]         pb_q, pb_d;     // previous slot winner
  logic                     pbv_q, pbv_d;

  weight_t                  w_sel;
  logic signed [RUN_W-1:0]  w_s, t_s, val;
  logic                     sub, take;
  logic [IDX_W-1:0]         best_now;
  logic [TOTAL_W-1:0]       total_sum;
  logic [LEN_W-1:0]         len_sum;

  always_comb begin
    w_sel     = weights_i[IDX_W'(srv_q)];
    w_s       = signed'(RUN_W'(w_sel));
    t_s       = signed'(RUN_W'(total_q));
    // winner of the last slot pays the total back as it comes around
    sub       = pbv_q && (pb_q == IDX_W'(srv_q));
    val       = ring_q[0] + w_s - (sub ? t_s : '0);
    take      = (w_sel != '0) && (!found_q || (val > top_q));
    best_now  = take ? IDX_W'(srv_q) : best_q;
    total_sum = total_q + TOTAL_W'(w_sel);
    len_sum   = (CMP_W'(total_sum) >= CMP_W'(SCHEDULE_DEPTH)) ?
                LEN_W'(SCHEDULE_DEPTH) : LEN_W'(total_sum);

    state_d = state_q;
    srv_d   = srv_q;
    slot_d  = slot_q;
    len_d   = len_q;
    total_d = total_q;
    top_d   = top_q;
    best_d  = best_q;
    found_d = found_q;
    pb_d    = pb_q;
    pbv_d   = pbv_q;
    wr_en_o = 1'b0;
    for (int k = 0; k < SERVERS; k++) begin
      ring_d[k] = ring_q[k];
    end

    unique case (state_q)
      ST_IDLE: begin
      end
      ST_SUM: begin
        total_d = total_sum;
        srv_d   = SRV_W'(srv_q + 1'b1);
        if (srv_q == LAST_SRV) begin
          srv_d   = '0;
          len_d   = len_sum;
          slot_d  = '0;
          found_d = 1'b0;
          pbv_d   = 1'b0;
          for (int k = 0; k < SERVERS; k++) begin
            ring_d[k] = '0;
          end
          state_d = (len_sum == '0) ? ST_IDLE : ST_SLOT;
        end
      end
      ST_SLOT: begin
        // ring rotates so the current server is always at the head
        for (int k = 0; k < SERVERS - 1; k++) begin
          ring_d[k] = ring_q[k+1];
        end
        ring_d[SERVERS-1] = val;
        if (take) begin
          top_d   = val;
          best_d  = IDX_W'(srv_q);
          found_d = 1'b1;
        end
        srv_d = SRV_W'(srv_q + 1'b1);
        if (srv_q == LAST_SRV) begin
          wr_en_o = 1'b1;
          srv_d   = '0;
          found_d = 1'b0;
          pb_d    = best_now;
          pbv_d   = 1'b1;
          slot_d  = ADDR_W'(slot_q + 1'b1);
          if (LEN_W'(slot_q) == LEN_W'(len_q - 1'b1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (start_i) begin
      state_d = ST_SUM;
      srv_d   = '0;
      total_d = '0;
      len_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      srv_q   <= '0;
      slot_q  <= '0;
      len_q   <= '0;
      total_q <= '0;
      top_q   <= '0;
      best_q  <= '0;
      found_q <= 1'b0;
      pb_q    <= '0;
      pbv_q   <= 1'b0;
      for (int k = 0; k < SERVERS; k++) begin
        ring_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      srv_q   <= srv_d;
      slot_q  <= slot_d;
      len_q   <= len_d;
      total_q <= total_d;
      top_q   <= top_d;
      best_q  <= best_d;
      found_q <= found_d;
      pb_q    <= pb_d;
      pbv_q   <= pbv_d;
      for (int k = 0; k < SERVERS; k++) begin
        ring_q[k] <= ring_d[k];
      end
    end
  end

  assign busy_o    = (state_q != ST_IDLE);
  assign len_o     = len_q;
  assign wr_addr_o = slot_q;
  assign wr_data_o = best_now;

`ifndef SYNTHESIS
  a_wr_srv_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |-> (int'(wr_data_o) < SERVERS))
    else $error("schedule entry names a server beyond the configured count");
  a_wr_in_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |-> (LEN_W'(wr_addr_o) < len_q))
    else $error("schedule write beyond the schedule length");
  a_slot_has_winner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |-> (found_q || take))
    else $error("slot closed without any weighted server");
`endif

endmodule

>>> hw/rtl/swrr_pick.sv
// Walker: reads one slot per cycle while output is free; skips tried servers.
module swrr_pick #(
  parameter int SCHEDULE_DEPTH = swrr_pkg::DEPTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  clr_i,
  input  logic                                  busy_i,
  input  logic [$clog2(SCHEDULE_DEPTH+1)-1:0]   len_i,
  input  logic                                  s_valid_i,
  output logic                                  s_ready_o,
  input  logic [swrr_pkg::NUM_REGS-1:0]         s_mask_i,
  output logic                                  m_valid_o,
  input  logic                                  m_ready_i,
  output logic [swrr_pkg::IDX_W-1:0]            m_server_o,
  output logic                                  m_none_o,
  output logic                                  rd_en_o,
  output logic [$clog2(SCHEDULE_DEPTH)-1:0]     rd_addr_o,
  input  logic [swrr_pkg::IDX_W-1:0]            rd_data_i
);
  import swrr_pkg::*;

  localparam int ADDR_W = $clog2(SCHEDULE_DEPTH);
  localparam int LEN_W  = $clog2(SCHEDULE_DEPTH + 1);

  typedef enum logic {ST_IDLE, ST_WALK} state_e;

  state_e               state_q, state_d;
  logic [ADDR_W-1:0]    pos_q, pos_d;
  logic [ADDR_W-1:0]    cur_q, cur_d;
  logic [LEN_W-1:0]     cnt_q, cnt_d;
  logic [NUM_REGS-1:0]  mask_q, mask_d;
  logic                 m_valid_q, m_valid_d;
  logic [IDX_W-1:0]     server_q, server_d;
  logic                 none_q, none_d;
  logic                 out_free;
  logic [ADDR_W-1:0]    cur_nxt;

  function automatic logic [ADDR_W-1:0] wrap_inc(input logic [ADDR_W-1:0] a,
                                                 input logic [LEN_W-1:0]  n);
    logic [LEN_W-1:0] s;
    s = LEN_W'(a) + 1'b1;
    return (s == n) ? '0 : ADDR_W'(s);
  endfunction

  assign out_free  = !m_valid_q || m_ready_i;
  assign s_ready_o = (state_q == ST_IDLE) && !busy_i && out_free;
  assign cur_nxt   = wrap_inc(cur_q, len_i);

  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    cur_d     = cur_q;
    cnt_d     = cnt_q;
    mask_d    = mask_q;
    m_valid_d = m_valid_q;
    server_d  = server_q;
    none_d    = none_q;
    rd_en_o   = 1'b0;
    rd_addr_o = cur_nxt;

    if (m_valid_q && m_ready_i) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_valid_i && s_ready_o) begin
          if (len_i == '0) begin
            m_valid_d = 1'b1;
            server_d  = '0;
            none_d    = 1'b1;
          end else begin
            mask_d    = s_mask_i;
            cur_d     = pos_q;
            cnt_d     = '0;
            rd_en_o   = 1'b1;
            rd_addr_o = pos_q;
            state_d   = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        // read data stays put while the output register is full
        if (out_free) begin
          if (!mask_q[rd_data_i] || (cnt_q == LEN_W'(len_i - 1'b1))) begin
            m_valid_d = 1'b1;
            server_d  = rd_data_i;
            none_d    = 1'b0;
            pos_d     = wrap_inc(pos_q, len_i);
            state_d   = ST_IDLE;
          end else begin
            cur_d   = cur_nxt;
            cnt_d   = LEN_W'(cnt_q + 1'b1);
            rd_en_o = 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (clr_i) begin
      state_d = ST_IDLE;
      pos_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pos_q     <= '0;
      cur_q     <= '0;
      cnt_q     <= '0;
      mask_q    <= '0;
      m_valid_q <= 1'b0;
      server_q  <= '0;
      none_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      pos_q     <= pos_d;
      cur_q     <= cur_d;
      cnt_q     <= cnt_d;
      mask_q    <= mask_d;
      m_valid_q <= m_valid_d;
      server_q  <= server_d;
      none_q    <= none_d;
    end
  end

  assign m_valid_o  = m_valid_q;
  assign m_server_o = server_q;
  assign m_none_o   = none_q;

`ifndef SYNTHESIS
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_o && m_none_o) |-> (m_server_o == '0))
    else $error("empty-schedule result carries a nonzero server");
  a_pos_in_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_i != '0) |-> (LEN_W'(pos_q) < len_i))
    else $error("schedule position outside the schedule length");
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_o && !m_ready_i) |=>
      (m_valid_o && $stable(m_server_o) && $stable(m_none_o)))
    else $error("pending result dropped or changed before it was taken");
`endif

endmodule

>>> hw/rtl/smooth_weighted_round_robin.sv
// Top level of the smooth weighted round-robin picker (config regs, builder, walker, RAM).
// Pick: with no weight set, no_server is returned without a schedule read; else tried
//   slots are skipped (at most length - 1); a new request is taken as a result leaves.
// Rebuild after any weight write: a sum pass, then min(total, SCHEDULE_DEPTH) slots,
//   one server per cycle through the shared add/compare unit; no request taken meanwhile.
// Reset: weights, total and position clear to zero; the schedule RAM is not cleared.
module smooth_weighted_round_robin #(
  parameter int SERVERS        = swrr_pkg::SERVERS_DEF,
  parameter int SCHEDULE_DEPTH = swrr_pkg::DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // APB-style register port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [swrr_pkg::PADDR_W-1:0]    paddr,
  input  logic [swrr_pkg::PDATA_W-1:0]    pwdata,
  output logic [swrr_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready,
  // pick requests
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [swrr_pkg::S_TDATA_W-1:0]  s_axis_tdata,   // [7:0] tried_mask
  // pick results
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [swrr_pkg::M_TDATA_W-1:0]  m_axis_tdata,   // [2:0] chosen_server, [7:3] zero
  output logic [0:0]                      m_axis_tuser    // [0] no_server
);
  import swrr_pkg::*;

  localparam int ADDR_W = $clog2(SCHEDULE_DEPTH);
  localparam int LEN_W  = $clog2(SCHEDULE_DEPTH + 1);

  weights_t                     weights_q;
  logic                         cfg_wr;
  logic [PADDR_W-REG_LSB-1:0]   reg_sel;

  logic                         build_busy;
  logic [LEN_W-1:0]             sched_len;
  logic                         wr_en;
  logic [ADDR_W-1:0]            wr_addr;
  logic [IDX_W-1:0]             wr_data;
  logic                         rd_en;
  logic [ADDR_W-1:0]            rd_addr;
  logic [IDX_W-1:0]             rd_data;
  logic [IDX_W-1:0]             pick_server;
  logic                         pick_none;

  // Register file: eight 8-bit weights, written in the APB access phase.
  // Every write starts a fresh rebuild; a write during a rebuild restarts it.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = paddr[PADDR_W-1:REG_LSB];
  assign prdata  = PDATA_W'(weights_q[reg_sel]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weights_q <= '0;
    end else if (cfg_wr) begin
      weights_q[reg_sel] <= pwdata[WEIGHT_W-1:0];
    end
  end

  // Builder: sums the weights, then runs the smooth WRR contest slot by slot
  // and streams the winners into the schedule RAM.
  swrr_build #(
    .SERVERS        (SERVERS),
    .SCHEDULE_DEPTH (SCHEDULE_DEPTH)
  ) u_build (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cfg_wr),
    .weights_i (weights_q),
    .busy_o    (build_busy),
    .len_o     (sched_len),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data)
  );

  // Schedule store: one server index per slot.
  swrr_ram #(
    .WIDTH (IDX_W),
    .DEPTH (SCHEDULE_DEPTH)
  ) u_sched (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Walker: starts at the position counter, returns the first untried server
  // (or the last one looked at; no_server if the schedule is empty), then bumps the position with wrap.
  swrr_pick #(
    .SCHEDULE_DEPTH (SCHEDULE_DEPTH)
  ) u_pick (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clr_i      (cfg_wr),
    .busy_i     (build_busy),
    .len_i      (sched_len),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_o  (s_axis_tready),
    .s_mask_i   (s_axis_tdata[NUM_REGS-1:0]),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_server_o (pick_server),
    .m_none_o   (pick_none),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data)
  );

  assign m_axis_tdata = M_TDATA_W'(pick_server);
  assign m_axis_tuser = pick_none;

endmodule
